[sv/sru_pkg.sv]
// ----------------------------------------------------------------------------
// Shift and rotate unit package
// Operation codes and the packed transaction types of the input and result
// channels.
// ----------------------------------------------------------------------------
package sru_pkg;

	// Operation codes of the shift and rotate group.
	typedef enum logic [2:0] {
		FUNC_ROL   = 3'd0,
		FUNC_ROR   = 3'd1,
		FUNC_RCL   = 3'd2,
		FUNC_RCR   = 3'd3,
		FUNC_SHL   = 3'd4,
		FUNC_SHR   = 3'd5,
		FUNC_UNDEF = 3'd6,
		FUNC_SAR   = 3'd7
	} func_t;

	// Operand widths expressed as shift counts.
	localparam logic [7:0] BYTE_BITS = 8'd8;
	localparam logic [7:0] WORD_BITS = 8'd16;

	// Input transaction.
	typedef struct packed {
		func_t       func;
		logic        is_word;
		logic [15:0] operand;
		logic [7:0]  count;
		logic        carry_in;
	} sru_in_t;

	// Result transaction.
	typedef struct packed {
		logic [15:0] result;
		logic        write_back;
		logic        cf_of_update;
		logic        carry_out;
		logic        overflow_out;
		logic        szp_update;
		logic        sign_out;
		logic        zero_out;
		logic        parity_out;
	} sru_out_t;

endpackage

[sv/shift_rotate_unit_top.sv]
// ----------------------------------------------------------------------------
// Shift and rotate unit
// Three-stage pipelined ROL, ROR, RCL, RCR, SHL, SHR and SAR on 8-bit or
// 16-bit operands, with flag results and update enables.
// ----------------------------------------------------------------------------
// The unit takes one transaction per cycle while the result side is not
// stalled. A transaction passes through the stage one and stage two registers
// and the output register before its result is presented. Stage one masks the
// count and reduces it to a shift amount (including the modulo 9 or 17 for the
// rotates through carry), stage two runs the funnel and barrel shifters, and
// stage three forms the flags into the output register. Each stage advances
// whenever the stage after it is empty or moving, so bubbles are squeezed out
// and a stall at the output holds every item that has no empty stage ahead.
// The mask_count register resets to one and is written through the
// configuration channel, which is always ready.
module shift_rotate_unit_top
	import sru_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  sru_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output sru_out_t out_data,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic     cfg_data
);

	logic mask_count_q;

	// Pipeline control.
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	// Stage one combinational signals.
	logic [7:0]        cnt_m;
	logic [7:0]        w_cnt;
	logic [15:0]       src;
	logic signed [5:0] d17, d9;
	logic [4:0]        rc17, rc9;
	logic [4:0]        amt_c;
	logic              kill_c;

	// Stage one registers.
	func_t       func_s1;
	logic        word_s1;
	logic [15:0] src_s1;
	logic        cin_s1;
	logic        zc_s1;
	logic [4:0]  amt_s1;
	logic        kill_s1;
	logic        sw1_s1, sw2_s1;

	// Stage two combinational signals.
	logic [31:0]        ext32, rol32, ror32;
	logic [33:0]        ext34, rcl34, rcr34;
	logic [16:0]        shl17;
	logic [15:0]        xs;
	logic               fill;
	logic signed [17:0] v18, t18;
	logic [16:0]        y_c;
	logic [15:0]        r_c;
	logic               cf_c;

	// Stage two registers.
	func_t       func_s2;
	logic        word_s2;
	logic        zc_s2;
	logic        sw1_s2, sw2_s2;
	logic [15:0] r_s2;
	logic        cf_s2;

	// Stage three.
	sru_out_t res_c;
	sru_out_t res_s3;
	logic     rw1, rw2;

	// Configuration register; the channel never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_count_q <= 1'b1;
		end else if (cfg_valid) begin
			mask_count_q <= cfg_data;
		end
	end

	// Stage enables: a stage moves when its successor is empty or moving.
	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Stage one: mask the count and reduce it to a shift amount.
	always_comb begin
		cnt_m  = mask_count_q ? {3'b000, in_data.count[4:0]} : in_data.count;
		w_cnt  = in_data.is_word ? WORD_BITS : BYTE_BITS;
		src    = in_data.is_word ? in_data.operand : {8'h00, in_data.operand[7:0]};
		// Modulo 17: sixteen is minus one, so take the low nibble less the high one.
		d17    = $signed({2'b00, cnt_m[3:0]}) - $signed({2'b00, cnt_m[7:4]});
		rc17   = (d17 < 0) ? 5'(d17 + 6'sd17) : 5'(d17);
		// Modulo 9: sixty-four is one and eight is minus one.
		d9     = $signed({4'b0000, cnt_m[7:6]}) + $signed({3'b000, cnt_m[2:0]})
			- $signed({3'b000, cnt_m[5:3]});
		if (d9 < 0) begin
			rc9 = 5'(d9 + 6'sd9);
		end else if (d9 >= 6'sd9) begin
			rc9 = 5'(d9 - 6'sd9);
		end else begin
			rc9 = 5'(d9);
		end
		kill_c = 1'b0;
		unique case (in_data.func) inside
			FUNC_ROL, FUNC_ROR: begin
				amt_c = in_data.is_word ? {1'b0, cnt_m[3:0]} : {2'b00, cnt_m[2:0]};
			end
			FUNC_RCL, FUNC_RCR: begin
				amt_c = in_data.is_word ? rc17 : rc9;
			end
			FUNC_SHL, FUNC_SHR: begin
				kill_c = cnt_m > w_cnt;
				amt_c  = cnt_m[4:0];
			end
			FUNC_SAR: begin
				amt_c = (cnt_m >= w_cnt) ? w_cnt[4:0] : cnt_m[4:0];
			end
			default: begin
				amt_c = 5'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			func_s1 <= in_data.func;
			word_s1 <= in_data.is_word;
			src_s1  <= src;
			cin_s1  <= in_data.carry_in;
			zc_s1   <= (cnt_m == 8'd0);
			amt_s1  <= amt_c;
			kill_s1 <= kill_c;
			sw1_s1  <= in_data.is_word ? src[15] : src[7];
			sw2_s1  <= in_data.is_word ? src[14] : src[6];
		end
	end

	// Stage two: funnel shifters for the rotates, barrel shifters for the shifts.
	always_comb begin
		ext32 = word_s1 ? {src_s1, src_s1} : {16'h0000, src_s1[7:0], src_s1[7:0]};
		rol32 = ext32 << amt_s1;
		ror32 = ext32 >> amt_s1;
		ext34 = word_s1 ? {cin_s1, src_s1, cin_s1, src_s1}
			: {16'h0000, cin_s1, src_s1[7:0], cin_s1, src_s1[7:0]};
		rcl34 = ext34 << amt_s1;
		rcr34 = ext34 >> amt_s1;
		shl17 = {1'b0, src_s1} << amt_s1;
		// Right shifts keep one bit below the operand to catch the last bit out.
		fill  = (func_s1 == FUNC_SAR) && sw1_s1;
		xs    = word_s1 ? src_s1 : {{8{fill}}, src_s1[7:0]};
		v18   = $signed({fill, xs, 1'b0});
		t18   = v18 >>> amt_s1;
		y_c   = 17'd0;
		r_c   = 16'd0;
		cf_c  = 1'b0;
		case (func_s1) inside
			FUNC_ROL: begin
				r_c  = word_s1 ? rol32[31:16] : {8'h00, rol32[15:8]};
				cf_c = r_c[0];
			end
			FUNC_ROR: begin
				r_c  = word_s1 ? ror32[15:0] : {8'h00, ror32[7:0]};
				cf_c = word_s1 ? r_c[15] : r_c[7];
			end
			FUNC_RCL: begin
				y_c  = word_s1 ? rcl34[33:17] : {8'h00, rcl34[17:9]};
				r_c  = word_s1 ? y_c[15:0] : {8'h00, y_c[7:0]};
				cf_c = word_s1 ? y_c[16] : y_c[8];
			end
			FUNC_RCR: begin
				y_c  = word_s1 ? rcr34[16:0] : {8'h00, rcr34[8:0]};
				r_c  = word_s1 ? y_c[15:0] : {8'h00, y_c[7:0]};
				cf_c = word_s1 ? y_c[16] : y_c[8];
			end
			FUNC_SHL: begin
				if (!kill_s1) begin
					r_c  = word_s1 ? shl17[15:0] : {8'h00, shl17[7:0]};
					cf_c = word_s1 ? shl17[16] : shl17[8];
				end
			end
			FUNC_SHR, FUNC_SAR: begin
				if (!kill_s1) begin
					r_c  = word_s1 ? t18[16:1] : {8'h00, t18[8:1]};
					cf_c = t18[0];
				end
			end
			default: begin
				r_c = 16'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			func_s2 <= func_s1;
			word_s2 <= word_s1;
			zc_s2   <= zc_s1;
			sw1_s2  <= sw1_s1;
			sw2_s2  <= sw2_s1;
			r_s2    <= r_c;
			cf_s2   <= cf_c;
		end
	end

	// Stage three: flags and update enables.
	always_comb begin
		rw1   = word_s2 ? r_s2[15] : r_s2[7];
		rw2   = word_s2 ? r_s2[14] : r_s2[6];
		res_c = '0;
		if (!zc_s2) begin
			res_c.write_back = 1'b1;
			case (func_s2) inside
				FUNC_ROL, FUNC_RCL: begin
					res_c.result       = r_s2;
					res_c.cf_of_update = 1'b1;
					res_c.carry_out    = cf_s2;
					res_c.overflow_out = sw1_s2 ^ sw2_s2;
				end
				FUNC_ROR, FUNC_RCR: begin
					res_c.result       = r_s2;
					res_c.cf_of_update = 1'b1;
					res_c.carry_out    = cf_s2;
					res_c.overflow_out = rw2 ^ sw1_s2;
				end
				FUNC_SHL, FUNC_SHR, FUNC_SAR: begin
					res_c.result       = r_s2;
					res_c.cf_of_update = 1'b1;
					res_c.carry_out    = cf_s2;
					if (func_s2 == FUNC_SHL) begin
						res_c.overflow_out = sw1_s2 ^ sw2_s2;
					end else if (func_s2 == FUNC_SHR) begin
						res_c.overflow_out = sw1_s2;
					end
					res_c.szp_update = 1'b1;
					res_c.sign_out   = rw1;
					res_c.zero_out   = (r_s2 == 16'd0);
					res_c.parity_out = ~(^r_s2[7:0]);
				end
				default: begin
					res_c.result = 16'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			res_s3 <= res_c;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = res_s3;

`ifndef NO_ASSERTIONS
	// An empty output register always lets a new transaction in.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s3 |-> in_ready)
		else $error("input stalled while the output register is empty");

	// An item in stage two that cannot move is still there next cycle.
	a_s2_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !adv3 |=> v_s2)
		else $error("stage two item lost during a stall");

	// Byte results never carry bits in the upper byte.
	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !word_s2 |-> r_s2[15:8] == 8'h00)
		else $error("byte result has upper bits set");

	// Sign, zero and parity are only written together with carry and overflow.
	a_szp_implies_cf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.szp_update |-> out_data.cf_of_update && out_data.write_back)
		else $error("flag update without carry update or write");

	// A transaction that writes nothing changes no flag.
	a_no_write_no_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.write_back |-> !out_data.cf_of_update
			&& !out_data.szp_update && out_data.result == 16'd0)
		else $error("flags updated on a zero count");
`endif

endmodule
